// ----- rtl/enc_pkg.sv -----
// Package for the exact numeric type conversion unit.
// Holds the word types, the type codes and the decoded-number record.
// No dependencies.
package enc_pkg;

    localparam int ValueWidth = 64;
    localparam int FuncWidth  = 7;

    typedef struct packed {
        logic [63:0] value_bits;
        logic [6:0]  func;
    } enc_in_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        exact;
    } enc_out_t;

    typedef enum logic [3:0] {
        CODE_F64 = 4'd0,
        CODE_F32 = 4'd1,
        CODE_S8  = 4'd2,
        CODE_S16 = 4'd3,
        CODE_S32 = 4'd4,
        CODE_S64 = 4'd5,
        CODE_U8  = 4'd6,
        CODE_U16 = 4'd7,
        CODE_U32 = 4'd8,
        CODE_U64 = 4'd9
    } code_t;

    typedef enum logic [1:0] {
        CLS_FINITE = 2'd0,
        CLS_INF    = 2'd1,
        CLS_NAN    = 2'd2
    } cls_t;

    // Decoded operand: value = mag * 2^expo, with mag odd or zero.
    typedef struct packed {
        cls_t         cls;
        logic         neg;
        logic [63:0]  mag;
        logic [6:0]   len;
        logic [12:0]  expo;
        logic [51:0]  nfrac;
    } num_t;

endpackage

// ----- rtl/enc_decode.sv -----
// Source decoder of the exact numeric type conversion unit.
// Splits the raw source word into class, sign, odd magnitude and exponent.
// Depends on enc_pkg.
module enc_decode
    import enc_pkg::*;
(
    input  logic [63:0] value_bits,
    input  code_t       src,
    output num_t        num
);

    logic [63:0] v;
    logic [63:0] m;
    logic [12:0] e;
    logic [6:0]  tz;
    logic [6:0]  bl;
    logic [63:0] mo;

    always_comb
    begin
        num = '0;
        m = '0;
        e = '0;
        case (src)
            CODE_F64:
            begin
                v = value_bits;
                num.neg = v[63];
                if (v[62:52] == 11'h7FF)
                begin
                    num.cls = (v[51:0] == '0) ? CLS_INF : CLS_NAN;
                    num.nfrac = v[51:0];
                end
                else if (v[62:52] == '0)
                begin
                    m = {12'd0, v[51:0]};
                    e = -13'sd1074;
                end
                else
                begin
                    m = {11'd0, 1'b1, v[51:0]};
                    e = 13'({2'b0, v[62:52]}) - 13'd1075;
                end
            end
            CODE_F32:
            begin
                v = {32'd0, value_bits[31:0]};
                num.neg = v[31];
                if (v[30:23] == 8'hFF)
                begin
                    num.cls = (v[22:0] == '0) ? CLS_INF : CLS_NAN;
                    num.nfrac = {v[22:0], 29'd0};
                end
                else if (v[30:23] == '0)
                begin
                    m = {41'd0, v[22:0]};
                    e = -13'sd149;
                end
                else
                begin
                    m = {40'd0, 1'b1, v[22:0]};
                    e = 13'({5'b0, v[30:23]}) - 13'd150;
                end
            end
            CODE_S8:
            begin
                v = {56'd0, value_bits[7:0]};
                num.neg = v[7];
                m = v[7] ? {56'd0, 8'(-v[7:0])} : v;
            end
            CODE_S16:
            begin
                v = {48'd0, value_bits[15:0]};
                num.neg = v[15];
                m = v[15] ? {48'd0, 16'(-v[15:0])} : v;
            end
            CODE_S32:
            begin
                v = {32'd0, value_bits[31:0]};
                num.neg = v[31];
                m = v[31] ? {32'd0, 32'(-v[31:0])} : v;
            end
            CODE_S64:
            begin
                v = value_bits;
                num.neg = v[63];
                m = v[63] ? -v : v;
            end
            CODE_U8:  begin v = {56'd0, value_bits[7:0]};  m = v; end
            CODE_U16: begin v = {48'd0, value_bits[15:0]}; m = v; end
            CODE_U32: begin v = {32'd0, value_bits[31:0]}; m = v; end
            default:  begin v = value_bits; m = v; end
        endcase

        // Strip trailing zeros into the exponent.
        tz = '0;
        for (int i = 63; i >= 0; i--)
        begin
            if (m[i])
            begin
                tz = 7'(i);
            end
        end
        if (m == '0)
        begin
            tz = '0;
        end
        mo = m >> tz;
        bl = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (mo[i])
            begin
                bl = 7'(i + 1);
            end
        end
        num.mag = mo;
        num.len = bl;
        num.expo = e + 13'(tz);
    end

endmodule

// ----- rtl/exact_numeric_type_conversion.sv -----
// Exact numeric type conversion unit: takes one word per cycle unless
// out_ready stalls it, and returns one result word; an item spends two
// register stages inside, with one combinational decode and encode pass
// between them. Depends on enc_pkg and enc_decode.
module exact_numeric_type_conversion
    import enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  enc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output enc_out_t out_data
);

    logic     a_valid_reg;
    enc_in_t  a_data_reg;
    logic     b_valid_reg;
    enc_out_t b_data_reg;
    logic     b_take;
    logic     a_take;

    logic [3:0] tgt;
    logic [3:0] src;
    logic       fvalid;
    num_t       num;
    enc_out_t   res;

    assign b_take   = !b_valid_reg || out_ready;
    assign a_take   = !a_valid_reg || b_take;
    assign in_ready = a_take;
    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_take)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && in_valid)
        begin
            a_data_reg <= in_data;
        end
        if (b_take && a_valid_reg)
        begin
            b_data_reg <= res;
        end
    end

    // Split func into target and source codes with a small comparison chain.
    always_comb
    begin
        fvalid = a_data_reg.func <= 7'd99;
        tgt = '0;
        for (int t = 1; t < 10; t++)
        begin
            if (a_data_reg.func >= 7'(10 * t))
            begin
                tgt = 4'(t);
            end
        end
        src = 4'(a_data_reg.func - 7'(10 * tgt));
        if (!fvalid)
        begin
            src = '0;
            tgt = '0;
        end
    end

    enc_decode u_decode (
        .value_bits (a_data_reg.value_bits),
        .src        (code_t'(src)),
        .num        (num)
    );

    logic        sgn_tgt;
    logic [6:0]  tw;
    logic [63:0] lim;
    logic [63:0] mag;
    logic [63:0] wm;
    logic signed [13:0] top;
    logic signed [13:0] ex;

    always_comb
    begin
        res = '0;
        ex  = $signed({num.expo[12], num.expo});
        top = ex + 14'($signed({1'b0, num.len})) - 14'sd1;
        mag = '0;
        lim = '0;
        tw  = 7'd64;
        case (tgt)
            CODE_F32:           tw = 7'd32;
            CODE_S8, CODE_U8:   tw = 7'd8;
            CODE_S16, CODE_U16: tw = 7'd16;
            CODE_S32, CODE_U32: tw = 7'd32;
            default:            tw = 7'd64;
        endcase
        wm = (tw == 7'd64) ? '1 : ((64'd1 << tw[5:0]) - 64'd1);
        sgn_tgt = tgt inside {[CODE_S8:CODE_S64]};

        if (!fvalid)
        begin
            res = '0;
        end
        else if (tgt == src)
        begin
            // Same type: the mask of the target width is the source width.
            res.result_bits = a_data_reg.value_bits & wm;
            res.exact = 1'b1;
        end
        else if (tgt >= CODE_S8)
        begin
            if (num.cls == CLS_FINITE)
            begin
                if (num.mag == '0)
                begin
                    res.exact = 1'b1;
                end
                else if (!ex[13] && (ex + 14'($signed({1'b0, num.len}))) <= 14'sd64)
                begin
                    mag = num.mag << ex[5:0];
                    if (sgn_tgt)
                    begin
                        lim = (64'd1 << (tw - 7'd1)) - 64'd1 + 64'(num.neg);
                    end
                    else
                    begin
                        lim = num.neg ? 64'd0 : wm;
                    end
                    if (!(!sgn_tgt && num.neg) && mag <= lim)
                    begin
                        res.exact = 1'b1;
                        res.result_bits = (num.neg ? -mag : mag) & wm;
                    end
                end
            end
        end
        else
        begin
            res.exact = 1'b1;
            if (tgt == CODE_F64)
            begin
                if (num.cls == CLS_NAN)
                begin
                    res.result_bits = {num.neg, 11'h7FF, 1'b1, num.nfrac[50:0]};
                end
                else if (num.cls == CLS_INF)
                begin
                    res.result_bits = {num.neg, 11'h7FF, 52'd0};
                end
                else if (num.mag == '0)
                begin
                    res.result_bits = {num.neg, 63'd0};
                end
                else if (num.len > 7'd53 || ex < -14'sd1074 || top > 14'sd1023)
                begin
                    res.exact = 1'b0;
                end
                else if (top >= -14'sd1022)
                begin
                    res.result_bits = {num.neg, 11'(top + 14'sd1023),
                        52'(num.mag << (7'd53 - num.len))};
                end
                else
                begin
                    res.result_bits = {num.neg, 63'(num.mag << 6'(ex + 14'sd1074))};
                end
            end
            else
            begin
                if (num.cls == CLS_NAN)
                begin
                    res.result_bits = {32'd0, num.neg, 8'hFF, 1'b1, num.nfrac[50:29]};
                end
                else if (num.cls == CLS_INF)
                begin
                    res.result_bits = {32'd0, num.neg, 8'hFF, 23'd0};
                end
                else if (num.mag == '0)
                begin
                    res.result_bits = {32'd0, num.neg, 31'd0};
                end
                else if (num.len > 7'd24 || ex < -14'sd149 || top > 14'sd127)
                begin
                    res.exact = 1'b0;
                end
                else if (top >= -14'sd126)
                begin
                    res.result_bits = {32'd0, num.neg, 8'(top + 14'sd127),
                        23'(num.mag << (7'd24 - num.len))};
                end
                else
                begin
                    res.result_bits = {32'd0, num.neg,
                        31'(num.mag << 5'(ex + 14'sd149))};
                end
            end
        end
        if (!res.exact)
        begin
            res.result_bits = '0;
        end
    end

endmodule
